@@ sv/qesp_pkg.sv @@
// Shared types and constants for the quadrature encoder speed PI/PWM core.
// No dependencies; imported by every module of the block.
package qesp_pkg;

  localparam int CHANNELS   = 4;
  localparam int COUNT_BITS = 16;
  localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam int TGT_W     = 16;
  localparam int DUTY_W    = 12;
  localparam int GAIN_W    = 16;
  localparam int DB_W      = 12;
  localparam int FS_W      = 12;
  localparam int SPD_FRAC  = 4;
  localparam int GAIN_FRAC = 12;
  localparam int SPD_W     = 32;
  localparam int ERR_W     = 33;
  localparam int MB_W      = GAIN_W + 1;
  localparam int PROD_W    = ERR_W + MB_W;
  localparam int PI_W      = PROD_W - GAIN_FRAC + 1;
  localparam int PIC_W     = FS_W + SPD_FRAC + 1;

  localparam int IN_BITS   = CHANNELS * (COUNT_BITS + TGT_W);
  localparam int IN_W      = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS  = CHANNELS * (DUTY_W + 1);
  localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8;
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;

  typedef enum logic [2:0] {
    STEP_DELTA,
    STEP_SPEED,
    STEP_ERR,
    STEP_MUL_I,
    STEP_INTEG,
    STEP_PI,
    STEP_CLAMP,
    STEP_FINISH
  } step_e;

  typedef struct packed {
    logic [GAIN_W-1:0] prop_gain;
    logic [GAIN_W-1:0] integral_gain;
    logic [GAIN_W-1:0] speed_per_count;
    logic [DB_W-1:0]   dead_band;
    logic [FS_W-1:0]   full_scale;
  } cfg_t;

  typedef struct packed {
    logic            run;
    step_e           step;
    logic [CH_W-1:0] ch;
  } ctl_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic              rev;
  } res_t;

endpackage

@@ sv/quad_encoder_speed_pi_pwm_core.sv @@
// Four-channel quadrature speed PI controller with deadband and PWM drive.
// Each input transaction runs 8 steps per channel on the shared multiplier and
// adder, for 4 channels in turn, then loads the output register once the output
// side is free. No new input is accepted until that load has happened.
// Reset (rst_ni low, async): speed, counter and integrator state cleared,
// registers to their defaults, no output pending. Depends on qesp_pkg.
module quad_encoder_speed_pi_pwm_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // count_a..count_d, target_a..target_d
  input  logic [qesp_pkg::IN_W-1:0]     s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // duty_a..duty_d, reverse_a..reverse_d, zero pad
  output logic [qesp_pkg::OUT_W-1:0]    m_axis_tdata,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [qesp_pkg::ADDR_W-1:0]   paddr,
  input  logic [qesp_pkg::DATA_W-1:0]   pwdata,
  output logic [qesp_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import qesp_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DONE
  } state_e;

  state_e            state_q;
  step_e             step_q;
  logic [CH_W-1:0]   ch_q;
  logic              m_valid_q;
  logic [IN_W-1:0]   in_q;
  res_t              res_q [CHANNELS];
  logic [OUT_W-1:0]  out_q;
  logic [OUT_W-1:0]  out_d;

  cfg_t              cfg;
  ctl_t              ctl;
  res_t              res;
  logic [COUNT_BITS-1:0] count_sel;
  logic [TGT_W-1:0]  target_sel;
  logic              last_ch;
  logic              out_free;

  qesp_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign count_sel  = in_q[ch_q*COUNT_BITS +: COUNT_BITS];
  assign target_sel = in_q[CHANNELS*COUNT_BITS + ch_q*TGT_W +: TGT_W];

  assign ctl.run  = (state_q == S_RUN);
  assign ctl.step = step_q;
  assign ctl.ch   = ch_q;

  qesp_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .ctl_i    (ctl),
    .count_i  (count_sel),
    .target_i (target_sel),
    .res_o    (res)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = out_q;
  assign last_ch       = (ch_q == CH_W'(CHANNELS - 1));
  assign out_free      = !m_valid_q || m_axis_tready;

  always_comb begin
    out_d = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      out_d[c*DUTY_W +: DUTY_W]  = res_q[c].duty;
      out_d[CHANNELS*DUTY_W + c] = res_q[c].rev;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      step_q    <= STEP_DELTA;
      ch_q      <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (state_q == S_DONE && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            state_q <= S_RUN;
            step_q  <= STEP_DELTA;
            ch_q    <= '0;
          end
        end
        S_RUN: begin
          step_q <= step_e'(step_q + 3'd1);
          if (step_q == STEP_FINISH) begin
            if (last_ch) begin
              state_q <= S_DONE;
            end else begin
              ch_q <= ch_q + 1'b1;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_q <= s_axis_tdata;
    end
    if (state_q == S_RUN && step_q == STEP_FINISH) begin
      res_q[ch_q] <= res;
    end
    if (state_q == S_DONE && out_free) begin
      out_q <= out_d;
    end
  end

endmodule

@@ sv/qesp_cfg.sv @@
// APB register file for gains, speed scale, deadband and PWM full scale.
// Depends on qesp_pkg.
module qesp_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [qesp_pkg::ADDR_W-1:0]   paddr,
  input  logic [qesp_pkg::DATA_W-1:0]   pwdata,
  output logic [qesp_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output qesp_pkg::cfg_t                cfg_o
);
  import qesp_pkg::*;

  localparam logic [2:0] REG_PROP  = 3'd0;
  localparam logic [2:0] REG_INTEG = 3'd1;
  localparam logic [2:0] REG_SCALE = 3'd2;
  localparam logic [2:0] REG_DB    = 3'd3;
  localparam logic [2:0] REG_FS    = 3'd4;

  cfg_t       cfg_q;
  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = paddr[4:2];
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain       <= GAIN_W'(4096);
      cfg_q.integral_gain   <= GAIN_W'(410);
      cfg_q.speed_per_count <= GAIN_W'(15000);
      cfg_q.dead_band       <= DB_W'(10);
      cfg_q.full_scale      <= FS_W'(4095);
    end else if (wr_en) begin
      case (idx)
        REG_PROP:  cfg_q.prop_gain       <= pwdata[GAIN_W-1:0];
        REG_INTEG: cfg_q.integral_gain   <= pwdata[GAIN_W-1:0];
        REG_SCALE: cfg_q.speed_per_count <= pwdata[GAIN_W-1:0];
        REG_DB:    cfg_q.dead_band       <= pwdata[DB_W-1:0];
        REG_FS:    cfg_q.full_scale      <= pwdata[FS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_PROP:  prdata = DATA_W'(cfg_q.prop_gain);
      REG_INTEG: prdata = DATA_W'(cfg_q.integral_gain);
      REG_SCALE: prdata = DATA_W'(cfg_q.speed_per_count);
      REG_DB:    prdata = DATA_W'(cfg_q.dead_band);
      REG_FS:    prdata = DATA_W'(cfg_q.full_scale);
      default:   prdata = '0;
    endcase
  end

endmodule

@@ sv/qesp_dp.sv @@
// Per-channel datapath: shared 33x17 multiplier, add/saturate/clamp steps,
// and the speed, counter and integrator state. Depends on qesp_pkg.
module qesp_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  qesp_pkg::cfg_t                  cfg_i,
  input  qesp_pkg::ctl_t                  ctl_i,
  input  logic [qesp_pkg::COUNT_BITS-1:0] count_i,
  input  logic [qesp_pkg::TGT_W-1:0]      target_i,
  output qesp_pkg::res_t                  res_o
);
  import qesp_pkg::*;

  localparam int SUM_W = PROD_W + 1;
  localparam logic signed [SPD_W-1:0] SPD_MAX = {1'b0, {(SPD_W-1){1'b1}}};
  localparam logic signed [SPD_W-1:0] SPD_MIN = {1'b1, {(SPD_W-1){1'b0}}};

  logic signed [SPD_W-1:0]  ms_q [CHANNELS];
  logic [COUNT_BITS-1:0]    prev_q [CHANNELS];
  logic signed [SPD_W-1:0]  isum_q [CHANNELS];

  logic signed [PROD_W-1:0] prod_q;
  logic signed [ERR_W-1:0]  err_q;
  logic signed [SPD_W-1:0]  integ_q;
  logic signed [PI_W-1:0]   pi_q;
  logic signed [PIC_W-1:0]  pic_q;

  logic signed [SPD_W-1:0]  ms_rd, isum_rd;
  logic [COUNT_BITS-1:0]    diff;
  logic signed [ERR_W-1:0]  mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] prod_d;
  logic                     mul_en;
  logic signed [SUM_W-1:0]  spd_sum, spd_sh;
  logic signed [SPD_W-1:0]  spd_d;
  logic signed [ERR_W-1:0]  err_d;
  logic signed [PI_W-1:0]   isum_d;
  logic signed [SPD_W-1:0]  integ_d;
  logic signed [PI_W-1:0]   pi_d;
  logic signed [PI_W-1:0]   fs_pos, fs_neg;
  logic signed [PIC_W-1:0]  pic_d;
  logic signed [PIC_W-1:0]  db_pos, db_neg;
  logic                     dead;
  logic signed [PIC_W-1:0]  pi_eff, pi_adj;
  logic signed [PIC_W-SPD_FRAC-1:0] n;

  assign ms_rd   = ms_q[ctl_i.ch];
  assign isum_rd = isum_q[ctl_i.ch];
  assign diff    = count_i - prev_q[ctl_i.ch];

  // shared multiplier operand select
  always_comb begin
    mul_a  = err_q;
    mul_b  = {1'b0, cfg_i.prop_gain};
    mul_en = 1'b0;
    case (ctl_i.step)
      STEP_DELTA: begin
        mul_a  = {{(ERR_W-COUNT_BITS){diff[COUNT_BITS-1]}}, diff};
        mul_b  = {1'b0, cfg_i.speed_per_count};
        mul_en = 1'b1;
      end
      STEP_MUL_I: begin
        mul_b  = {1'b0, cfg_i.integral_gain};
        mul_en = 1'b1;
      end
      STEP_INTEG: begin
        mul_b  = {1'b0, cfg_i.prop_gain};
        mul_en = 1'b1;
      end
      default: ;
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // speed update with saturation
  assign spd_sum = {{(SUM_W-SPD_W){ms_rd[SPD_W-1]}}, ms_rd} + {prod_q[PROD_W-1], prod_q};
  assign spd_sh  = spd_sum >>> 2;
  always_comb begin
    if (spd_sh > SPD_MAX) begin
      spd_d = SPD_MAX;
    end else if (spd_sh < SPD_MIN) begin
      spd_d = SPD_MIN;
    end else begin
      spd_d = spd_sh[SPD_W-1:0];
    end
  end

  assign err_d = {{(ERR_W-TGT_W-SPD_FRAC){target_i[TGT_W-1]}}, target_i, {SPD_FRAC{1'b0}}}
               - {{(ERR_W-SPD_W){ms_rd[SPD_W-1]}}, ms_rd};

  // integrator with saturation
  assign isum_d = {{(PI_W-SPD_W){isum_rd[SPD_W-1]}}, isum_rd}
                + {prod_q[PROD_W-1], prod_q[PROD_W-1:GAIN_FRAC]};
  always_comb begin
    if (isum_d > SPD_MAX) begin
      integ_d = SPD_MAX;
    end else if (isum_d < SPD_MIN) begin
      integ_d = SPD_MIN;
    end else begin
      integ_d = isum_d[SPD_W-1:0];
    end
  end

  assign pi_d = {prod_q[PROD_W-1], prod_q[PROD_W-1:GAIN_FRAC]}
              + {{(PI_W-SPD_W){integ_q[SPD_W-1]}}, integ_q};

  // output clamp
  assign fs_pos = {{(PI_W-FS_W-SPD_FRAC){1'b0}}, cfg_i.full_scale, {SPD_FRAC{1'b0}}};
  assign fs_neg = -fs_pos;
  always_comb begin
    if (pi_q > fs_pos) begin
      pic_d = fs_pos[PIC_W-1:0];
    end else if (pi_q < fs_neg) begin
      pic_d = fs_neg[PIC_W-1:0];
    end else begin
      pic_d = pi_q[PIC_W-1:0];
    end
  end

  // deadband, truncation toward zero, reverse flag plus duty (full_scale + n when negative)
  assign db_pos = {1'b0, cfg_i.dead_band, {SPD_FRAC{1'b0}}};
  assign db_neg = -db_pos;
  assign dead   = (pic_q > db_neg) && (pic_q < db_pos);
  assign pi_eff = dead ? '0 : pic_q;
  assign pi_adj = pi_eff[PIC_W-1] ? (pi_eff + PIC_W'(15)) : pi_eff;
  assign n      = pi_adj[PIC_W-1:SPD_FRAC];

  always_comb begin
    res_o.rev = n[PIC_W-SPD_FRAC-1];
    if (n[PIC_W-SPD_FRAC-1]) begin
      res_o.duty = cfg_i.full_scale + n[DUTY_W-1:0];
    end else begin
      res_o.duty = n[DUTY_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        ms_q[c]   <= '0;
        prev_q[c] <= '0;
        isum_q[c] <= '0;
      end
    end else if (ctl_i.run) begin
      if (ctl_i.step == STEP_SPEED) begin
        ms_q[ctl_i.ch]   <= spd_d;
        prev_q[ctl_i.ch] <= count_i;
      end
      if (ctl_i.step == STEP_FINISH) begin
        isum_q[ctl_i.ch] <= dead ? '0 : integ_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.run) begin
      if (mul_en) begin
        prod_q <= prod_d;
      end
      case (ctl_i.step)
        STEP_ERR:   err_q   <= err_d;
        STEP_INTEG: integ_q <= integ_d;
        STEP_PI:    pi_q    <= pi_d;
        STEP_CLAMP: pic_q   <= pic_d;
        default: ;
      endcase
    end
  end

endmodule
